// ----- design/gre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reachability engine package
// Shared sizes, codes, memory request type and helper functions.
// ----------------------------------------------------------------------------
package gre_pkg;

   localparam int MAX_NODES  = 32;
   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int ROW_BITS   = MAX_NODES;
   localparam int COUNT_BITS = 6;

   // Item kind carried in tuser.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic [ROW_BITS-1:0]  row_type;
   typedef logic [NODE_BITS-1:0] node_type;

   typedef struct packed {
      logic     wr_en;
      node_type wr_addr;
      row_type  wr_data;
      logic     rd_en;
      node_type rd_addr;
   } mem_req_type;

   // Number of nodes in use, capped at the matrix size.
   function automatic logic [COUNT_BITS-1:0] active_limit(input logic [COUNT_BITS-1:0] count);
      logic [COUNT_BITS-1:0] result;
      result = count;
      if (count > COUNT_BITS'(MAX_NODES)) begin
         result = COUNT_BITS'(MAX_NODES);
      end
      return result;
   endfunction

   // Columns below the limit.
   function automatic row_type column_mask(input logic [COUNT_BITS-1:0] limit);
      row_type result;
      for (int j = 0; j < ROW_BITS; j++) begin
         result[j] = (COUNT_BITS'(j) < limit);
      end
      return result;
   endfunction

   // Index of the lowest set bit; zero for an empty mask.
   function automatic node_type lowest_index(input row_type m);
      node_type result;
      result = '0;
      for (int j = ROW_BITS - 1; j >= 0; j--) begin
         if (m[j]) begin
            result = NODE_BITS'(j);
         end
      end
      return result;
   endfunction

endpackage

// ----- design/gre_adj_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency row memory
// One write and one registered read port; rows never written read as zero.
// ----------------------------------------------------------------------------
module gre_adj_mem
   import gre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output row_type     rd_data
);

   row_type               mem_ff [MAX_NODES];
   logic [MAX_NODES-1:0]  row_valid_ff;
   logic [MAX_NODES-1:0]  row_valid_in;
   row_type               rd_row_ff;
   logic                  rd_valid_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      if (mem_req.wr_en) begin
         row_valid_in[mem_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         if (mem_req.rd_en) begin
            rd_valid_ff <= row_valid_ff[mem_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_row_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_row_ff : '0;

endmodule

// ----- design/gre_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reachability search sequencer
// Takes items, writes rows, and expands one pending node per pass of the
// shared merge unit until no node is left; holds the result register.
// ----------------------------------------------------------------------------
module gre_search
   import gre_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  node_type              req_row_node,
   input  row_type               req_row_edges,
   input  node_type              req_start_node,
   input  logic [COUNT_BITS-1:0] limit,
   input  row_type               cols,
   output mem_req_type           mem_req,
   input  row_type               rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output row_type               rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PICK  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   row_type   visited_ff, visited_in;
   row_type   pending_ff, pending_in;
   row_type   start_bit_ff, start_bit_in;
   logic      rsp_valid_ff, rsp_valid_in;
   row_type   rsp_data_ff, rsp_data_in;
   row_type   fresh;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fresh     = rd_data & cols & ~visited_ff;

   always_comb begin
      state_in     = state_ff;
      visited_in   = visited_ff;
      pending_in   = pending_ff;
      start_bit_in = start_bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_req      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_WRITE) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = req_row_node;
                  mem_req.wr_data = req_row_edges;
               end else begin
                  start_bit_in = row_type'(1) << req_start_node;
                  if ({1'b0, req_start_node} >= limit) begin
                     // Start outside the active nodes answers an empty mask.
                     visited_in = '0;
                     pending_in = '0;
                     state_in   = ST_DONE;
                  end else begin
                     visited_in = row_type'(1) << req_start_node;
                     pending_in = row_type'(1) << req_start_node;
                     state_in   = ST_PICK;
                  end
               end
            end
         end
         ST_PICK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = lowest_index(pending_ff);
            pending_in      = pending_ff & (pending_ff - row_type'(1));
            state_in        = ST_MERGE;
         end
         ST_MERGE: begin
            visited_in = visited_ff | fresh;
            pending_in = pending_ff | fresh;
            state_in   = ((pending_ff | fresh) == '0) ? ST_DONE : ST_PICK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = visited_ff & ~start_bit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
         pending_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         pending_ff   <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      start_bit_ff <= start_bit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/graph_reachability_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph reachability engine
// Directed graph held as a 32 x 32 adjacency bit matrix; answers the set of
// nodes reachable from a start node.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per handshake. tuser is the mode: 0 writes
// adjacency row row_node with row_edges (bit j marks the edge to node j), 1
// asks for the nodes reachable from start_node. A write gives no result and
// keeps req_tready high. A query gives one rsp item whose tdata is the
// reachable mask, with the start bit always cleared and nodes at or above
// node_count left out.
// Search: a query expands one node per pass through a pick state, which takes
// the lowest pending node and reads its row from the registered memory port,
// and a merge state, in which the shared merge unit folds the row into the
// visited and pending masks. A start node outside the active range skips the
// expansion and goes straight to the done state. req_tready is low while a
// query runs, so the next item is taken only after the query's result has
// been registered.
// Reset clears the graph (every row reads as zero) and the result valid flag
// and sets node_count to 32. When the receiver stalls, a finished result
// waits in the rsp register while the engine returns to idle and still takes
// row writes; a following query runs but then waits in its final step, with
// req_tready low, until it drains. csr_wr_en with csr_wr_data writes
// node_count; the user must write it only when idle; the block does not check.
// ----------------------------------------------------------------------------
module graph_reachability_engine
   import gre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request item.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // row_node[4:0], row_edges[36:5], start_node[41:37], zero
   input  logic        req_tuser,   // mode
   // Result item.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // reachable_mask[31:0]
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data  // node_count
);

   logic [COUNT_BITS-1:0] node_count_ff;
   logic [COUNT_BITS-1:0] limit;
   row_type               cols;
   mem_req_type           mem_req;
   row_type               rd_data;

   // The node count register; the limit and column mask follow it directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_BITS'(MAX_NODES);
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   assign limit = active_limit(node_count_ff);
   assign cols  = column_mask(limit);

   gre_adj_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   gre_search u_search (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser),
      .req_row_node   (req_tdata[4:0]),
      .req_row_edges  (req_tdata[36:5]),
      .req_start_node (req_tdata[41:37]),
      .limit          (limit),
      .cols           (cols),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_data       (rsp_tdata)
   );

   // A row write never produces a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_WRITE) |=> !$rose(rsp_tvalid))
      else $error("result raised after a row write");

   // Results never report a node outside the active range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata & ~cols) == '0))
      else $error("result reports an inactive node");

   // A query out of range finishes with an empty mask.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == MODE_QUERY
       && {1'b0, req_tdata[41:37]} >= limit && !rsp_tvalid)
      |=> ##1 (rsp_tvalid && rsp_tdata == '0))
      else $error("out of range query did not answer zero");

   // Nothing leaves the rsp register right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
